// ----- rtl/tsjs_pkg.sv -----
// ----------------------------------------------------------------------------
// tsjs_pkg: thread scheduler package
// Shared types, command and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package tsjs_pkg;

   localparam int DEF_THREAD_CAP  = 32;
   localparam int DEF_NUM_SEMS    = 4;
   localparam int QDEPTH          = 32;
   localparam int QW              = 5;
   localparam int NUM_LIMITS      = 4;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0,
      CMD_YIELD  = 3'd1,
      CMD_TICK   = 3'd2,
      CMD_JOIN   = 3'd3,
      CMD_EXIT   = 3'd4,
      CMD_WAIT   = 3'd5,
      CMD_SIGNAL = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_YIELD_REF  = 3'd1,
      ST_NONE_READY = 3'd2,
      ST_LIMIT      = 3'd3,
      ST_NO_RUN     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_PUSH_CUR,
      S_EXIT_RD,
      S_EXIT_CHK,
      S_SIG_POP,
      S_DISPATCH,
      S_DISP_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [4:0] target_thread;
      logic [1:0] sem_index;
   } req_type;

   typedef struct packed {
      logic [4:0] running_thread;
      logic       running_valid;
      logic [4:0] new_thread;
      logic [2:0] status;
   } rsp_type;

endpackage

// ----- rtl/tsjs_if.sv -----
// ----------------------------------------------------------------------------
// tsjs_if: valid/ready channel
// Carries one item of a given payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface tsjs_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/tsjs_queues.sv -----
// ----------------------------------------------------------------------------
// tsjs_queues: shared queue memory
// Holds the ready, blocked and semaphore waiter FIFOs in one memory with one
// write and one registered read port; head and count pointers per queue.
// Queue 0 ready, 1 blocked, 2.. semaphore waiters.
// ----------------------------------------------------------------------------
module tsjs_queues #(
   parameter int NQ = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [$clog2(NQ)-1:0]    push_q,
   input  logic [tsjs_pkg::QW-1:0]  push_data,
   input  logic                     pop,
   input  logic [$clog2(NQ)-1:0]    pop_q,
   output logic [tsjs_pkg::QW-1:0]  pop_data,
   output logic [NQ-1:0]            nonempty
);
   import tsjs_pkg::*;
   localparam int AW = $clog2(QDEPTH);
   localparam int QIW = $clog2(NQ);

   logic [QW-1:0]  mem [NQ*QDEPTH];
   logic [AW-1:0]  head_ff [NQ];
   logic [AW:0]    cnt_ff [NQ];
   logic [QW-1:0]  rd_ff;
   logic [AW-1:0]  wptr;

   assign wptr     = head_ff[push_q] + cnt_ff[push_q][AW-1:0];
   assign pop_data = rd_ff;

   always_comb begin
      for (int q = 0; q < NQ; q++) begin
         nonempty[q] = (cnt_ff[q] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (push && cnt_ff[push_q] != (AW+1)'(QDEPTH)) begin
         mem[{push_q, wptr}] <= push_data;
      end
      rd_ff <= mem[{pop_q, head_ff[pop_q]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NQ; q++) begin
            head_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
      end else begin
         for (int q = 0; q < NQ; q++) begin
            logic inc, dec;
            inc = push && push_q == QIW'(q) && cnt_ff[q] != (AW+1)'(QDEPTH);
            dec = pop && pop_q == QIW'(q) && cnt_ff[q] != '0;
            if (dec) begin
               head_ff[q] <= head_ff[q] + 1'b1;
            end
            cnt_ff[q] <= cnt_ff[q] + (AW+1)'(inc) - (AW+1)'(dec);
         end
      end
   end
endmodule

// ----- rtl/thread_scheduler_join_semaphore_top.sv -----
// ----------------------------------------------------------------------------
// thread_scheduler_join_semaphore_top: hardware thread scheduler
// FIFO round-robin scheduler with join and counting semaphores.
// ----------------------------------------------------------------------------
// One event is handled at a time; the block drops req ready until the result
// item is taken. Every queue lives in one shared memory with one write and
// one registered read port, so each push or pop is a sequencer step: the
// first create pushes two ids, and exit walks the blocked list one entry at a
// time, a read state then a check state for each blocked thread.
module thread_scheduler_join_semaphore_top #(
   parameter int THREAD_CAP  = tsjs_pkg::DEF_THREAD_CAP,
   parameter int NUM_SEMS    = tsjs_pkg::DEF_NUM_SEMS
) (
   input  logic       clock,
   input  logic       reset,
   tsjs_if.sink       req,
   tsjs_if.source     rsp,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   import tsjs_pkg::*;
   localparam int NQ  = 2 + NUM_SEMS;
   localparam int QIW = $clog2(NQ);
   localparam int ID_LIMIT = (THREAD_CAP < 32) ? THREAD_CAP : 32;
   localparam logic [QIW-1:0] Q_READY = QIW'(0);
   localparam logic [QIW-1:0] Q_BLOCK = QIW'(1);

   state_type     state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [4:0]    cur_ff, cur_in;
   logic          curv_ff, curv_in;
   logic [5:0]    nid_ff, nid_in;
   logic          launched_ff, launched_in;
   logic [31:0]   fin_ff, fin_in;
   logic [7:0]    limit_ff [NUM_LIMITS];
   logic [7:0]    count_ff [NUM_SEMS];
   logic [4:0]    wtgt_ff [32];
   logic [5:0]    walk_ff, walk_in;
   logic [4:0]    newt_ff, newt_in;
   logic [2:0]    stat_ff, stat_in;
   logic          rsp_valid_ff;

   logic            q_push, q_pop;
   logic [QIW-1:0]  q_push_q, q_pop_q;
   logic [QW-1:0]   q_push_data, q_pop_data;
   logic [NQ-1:0]   q_ne;
   logic [5:0]      blk_cnt;
   logic            wt_we;
   logic            cnt_dec, cnt_inc;
   logic [QIW-1:0]  semq;
   logic            sem_ok;
   logic [7:0]      sel_count;

   tsjs_queues #(.NQ(NQ)) u_queues (
      .clock, .reset,
      .push(q_push), .push_q(q_push_q), .push_data(q_push_data),
      .pop(q_pop), .pop_q(q_pop_q), .pop_data(q_pop_data),
      .nonempty(q_ne)
   );

   // blocked-list length is tracked locally for the exit walk
   logic [5:0] blk_len_ff;
   assign blk_cnt = blk_len_ff;
   assign sem_ok = {30'd0, cmd_ff.sem_index} < NUM_SEMS;
   assign semq = QIW'(32'd2 + {30'd0, cmd_ff.sem_index});

   always_comb begin
      sel_count = '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
         if (cmd_ff.sem_index == 2'(i)) sel_count = count_ff[i];
      end
   end

   assign req.ready     = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.payload.running_thread = curv_ff ? cur_ff : 5'd0;
   assign rsp.payload.running_valid  = curv_ff;
   assign rsp.payload.new_thread     = newt_ff;
   assign rsp.payload.status         = stat_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; cur_in = cur_ff; curv_in = curv_ff;
      nid_in = nid_ff; launched_in = launched_ff; fin_in = fin_ff;
      walk_in = walk_ff; newt_in = newt_ff; stat_in = stat_ff;
      q_push = 1'b0; q_push_q = Q_READY; q_push_data = cur_ff;
      q_pop = 1'b0; q_pop_q = Q_READY;
      wt_we = 1'b0; cnt_dec = 1'b0; cnt_inc = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.payload; newt_in = '0; stat_in = ST_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (cmd_ff.command == CMD_CREATE && !launched_ff) begin
               if ({1'b0, nid_ff} + 7'd2 > 7'(ID_LIMIT)) begin
                  stat_in = ST_LIMIT;
               end else begin
                  newt_in = nid_ff[4:0]; q_push = 1'b1; q_push_data = nid_ff[4:0];
                  nid_in = nid_ff + 6'd1; launched_in = 1'b1;
                  state_in = S_PUSH_CUR; walk_in = '0;
               end
            end else if (cmd_ff.command != CMD_NONE && !curv_ff) begin
               stat_in = ST_NO_RUN;
            end else begin
               priority case (cmd_ff.command)
                  CMD_CREATE: begin
                     if (nid_ff >= 6'(ID_LIMIT)) stat_in = ST_LIMIT;
                     else begin
                        newt_in = nid_ff[4:0]; q_push = 1'b1;
                        q_push_data = nid_ff[4:0]; nid_in = nid_ff + 6'd1;
                     end
                  end
                  CMD_YIELD, CMD_TICK: begin
                     if (!q_ne[Q_READY]) begin
                        if (cmd_ff.command == CMD_YIELD) stat_in = ST_YIELD_REF;
                     end else begin
                        q_push = 1'b1; state_in = S_DISPATCH;
                     end
                  end
                  CMD_JOIN: begin
                     if (!fin_ff[cmd_ff.target_thread]) begin
                        wt_we = 1'b1; q_push = 1'b1; q_push_q = Q_BLOCK;
                        state_in = S_DISPATCH;
                     end
                  end
                  CMD_EXIT: begin
                     fin_in = fin_ff | (32'd1 << cur_ff);
                     walk_in = blk_cnt;
                     state_in = (blk_cnt == '0) ? S_DISPATCH : S_EXIT_RD;
                  end
                  CMD_WAIT: begin
                     if (sem_ok) begin
                        if (sel_count == '0) begin
                           q_push = 1'b1; q_push_q = semq; state_in = S_DISPATCH;
                        end else cnt_dec = 1'b1;
                     end
                  end
                  CMD_SIGNAL: begin
                     if (sem_ok) begin
                        if (q_ne[semq]) begin
                           q_pop_q = semq; state_in = S_SIG_POP;
                        end else cnt_inc = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PUSH_CUR: begin
            // second id of the first create, then dispatch
            q_push = 1'b1; q_push_data = nid_ff[4:0]; nid_in = nid_ff + 6'd1;
            state_in = S_DISPATCH;
         end
         S_EXIT_RD: begin
            q_pop_q = Q_BLOCK; state_in = S_EXIT_CHK;
         end
         S_EXIT_CHK: begin
            // pop the head already on the read port, requeue by target
            q_pop = 1'b1; q_pop_q = Q_BLOCK;
            q_push = 1'b1; q_push_data = q_pop_data;
            q_push_q = (wtgt_ff[q_pop_data] == cur_ff) ? Q_READY : Q_BLOCK;
            walk_in = walk_ff - 6'd1;
            state_in = (walk_ff == 6'd1) ? S_DISPATCH : S_EXIT_RD;
         end
         S_SIG_POP: begin
            q_pop = 1'b1; q_pop_q = semq;
            q_push = 1'b1; q_push_data = q_pop_data;
            state_in = S_DONE;
         end
         S_DISPATCH: begin
            q_pop_q = Q_READY;
            if (!q_ne[Q_READY]) begin
               curv_in = 1'b0; cur_in = '0;
               stat_in = ST_NONE_READY; state_in = S_DONE;
            end else state_in = S_DISP_WAIT;
         end
         S_DISP_WAIT: begin
            q_pop = 1'b1; q_pop_q = Q_READY;
            cur_in = q_pop_data; curv_in = 1'b1; stat_in = ST_OK;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wt_we) wtgt_ff[cur_ff] <= cmd_ff.target_thread;
      cmd_ff <= cmd_in; walk_ff <= walk_in; newt_ff <= newt_in; stat_ff <= stat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cur_ff <= '0; curv_ff <= 1'b0; nid_ff <= '0;
         launched_ff <= 1'b0; fin_ff <= '0; rsp_valid_ff <= 1'b0;
         blk_len_ff <= '0;
         for (int i = 0; i < NUM_LIMITS; i++) limit_ff[i] <= 8'd1;
         for (int i = 0; i < NUM_SEMS; i++) count_ff[i] <= 8'd1;
      end else begin
         state_ff <= state_in; cur_ff <= cur_in; curv_ff <= curv_in;
         nid_ff <= nid_in; launched_ff <= launched_in; fin_ff <= fin_in;
         blk_len_ff <= blk_len_ff
            + 6'(q_push && q_push_q == Q_BLOCK && blk_len_ff != 6'd32)
            - 6'(q_pop && q_pop_q == Q_BLOCK && blk_len_ff != 6'd0);
         if (state_ff == S_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SEMS; i++) begin
            if (cnt_dec && cmd_ff.sem_index == 2'(i))
               count_ff[i] <= count_ff[i] - 8'd1;
            else if (cnt_inc && cmd_ff.sem_index == 2'(i) && count_ff[i] < limit_ff[i])
               count_ff[i] <= count_ff[i] + 8'd1;
            else if (cnt_inc && cmd_ff.sem_index == 2'(i))
               count_ff[i] <= limit_ff[i];
            if (csr_write && csr_index == 2'(i)) count_ff[i] <= csr_data;
         end
         if (csr_write) limit_ff[csr_index] <= csr_data;
      end
   end
endmodule

// ----- tb/thread_scheduler_join_semaphore_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thread_scheduler_join_semaphore_checker: scheduler scoreboard
// Watches the event, result and register ports, predicts every result of
// the scheduler from its own copy of the queues and semaphores, and counts
// every mismatch, unexpected result and missing result.
// ----------------------------------------------------------------------------
module thread_scheduler_join_semaphore_checker
   import tsjs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_payload,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);

   localparam int ID_LIMIT = (DEF_THREAD_CAP < 32) ? DEF_THREAD_CAP : 32;

   logic [4:0] run_q[$];
   logic [4:0] joiner_q[$];
   logic [4:0] sem_q[4][$];
   logic [4:0] join_target[32];
   logic [31:0] done_map;
   logic [4:0] cur_id;
   logic        cur_on;
   logic [5:0] id_next;
   logic        started;
   logic [7:0] limit_reg[4];
   logic [7:0] count_reg[4];
   rsp_type    expected_rsp_q[$];

   function automatic status_type switch_to_head();
      if (run_q.size() == 0) begin
         cur_on = 1'b0;
         cur_id = '0;
         return ST_NONE_READY;
      end
      cur_id = run_q.pop_front();
      cur_on = 1'b1;
      return ST_OK;
   endfunction

   function automatic rsp_type schedule_event(req_type ev);
      status_type st;
      logic [4:0] made;
      logic [4:0] t;
      int         n;
      int         si;
      rsp_type    r;
      st = ST_OK;
      made = '0;
      si = ev.sem_index;
      if (cmd_type'(ev.command) == CMD_CREATE && !started) begin
         if (int'(id_next) + 2 > ID_LIMIT) begin
            st = ST_LIMIT;
         end else begin
            made = id_next[4:0];
            run_q.push_back(id_next[4:0]);
            run_q.push_back(5'(id_next + 1));
            id_next = id_next + 2;
            started = 1'b1;
            void'(switch_to_head());
         end
      end else if (cmd_type'(ev.command) != CMD_NONE && !cur_on) begin
         st = ST_NO_RUN;
      end else begin
         case (cmd_type'(ev.command))
            CMD_CREATE: begin
               if (int'(id_next) >= ID_LIMIT) begin
                  st = ST_LIMIT;
               end else begin
                  made = id_next[4:0];
                  run_q.push_back(id_next[4:0]);
                  id_next = id_next + 1;
               end
            end
            CMD_YIELD: begin
               if (run_q.size() == 0) begin
                  st = ST_YIELD_REF;
               end else begin
                  run_q.push_back(cur_id);
                  void'(switch_to_head());
               end
            end
            CMD_TICK: begin
               run_q.push_back(cur_id);
               void'(switch_to_head());
            end
            CMD_JOIN: begin
               if (!done_map[ev.target_thread]) begin
                  join_target[cur_id] = ev.target_thread;
                  joiner_q.push_back(cur_id);
                  st = switch_to_head();
               end
            end
            CMD_EXIT: begin
               done_map[cur_id] = 1'b1;
               n = joiner_q.size();
               for (int i = 0; i < n; i++) begin
                  t = joiner_q.pop_front();
                  if (join_target[t] == cur_id) run_q.push_back(t);
                  else joiner_q.push_back(t);
               end
               st = switch_to_head();
            end
            CMD_WAIT: begin
               if (count_reg[si] == 0) begin
                  sem_q[si].push_back(cur_id);
                  st = switch_to_head();
               end else begin
                  count_reg[si] = count_reg[si] - 1;
               end
            end
            CMD_SIGNAL: begin
               if (sem_q[si].size() > 0) run_q.push_back(sem_q[si].pop_front());
               else if (count_reg[si] < limit_reg[si]) count_reg[si] = count_reg[si] + 1;
               else count_reg[si] = limit_reg[si];
            end
            default: ;
         endcase
      end
      r.running_thread = cur_on ? cur_id : '0;
      r.running_valid  = cur_on;
      r.new_thread     = made;
      r.status         = st;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         run_q.delete();
         joiner_q.delete();
         for (int i = 0; i < 4; i++) begin
            sem_q[i].delete();
            limit_reg[i] = 8'd1;
            count_reg[i] = 8'd1;
         end
         for (int i = 0; i < 32; i++) join_target[i] = '0;
         done_map = '0;
         cur_id = '0;
         cur_on = 1'b0;
         id_next = '0;
         started = 1'b0;
         expected_rsp_q.delete();
         fail_count <= 0;
         checked_count <= 0;
      end else begin
         if (csr_write) begin
            limit_reg[csr_index] = csr_data;
            count_reg[csr_index] = csr_data;
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(schedule_event(req_payload));
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected result item %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want !== rsp_payload) begin
                  fail_count <= fail_count + 1;
                  if (want.running_thread !== rsp_payload.running_thread)
                     $error("running_thread expected %0d actual %0d",
                            want.running_thread, rsp_payload.running_thread);
                  if (want.running_valid !== rsp_payload.running_valid)
                     $error("running_valid expected %0d actual %0d",
                            want.running_valid, rsp_payload.running_valid);
                  if (want.new_thread !== rsp_payload.new_thread)
                     $error("new_thread expected %0d actual %0d",
                            want.new_thread, rsp_payload.new_thread);
                  if (want.status !== rsp_payload.status)
                     $error("status expected %0d actual %0d",
                            want.status, rsp_payload.status);
               end
            end
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

// ----- tb/thread_scheduler_join_semaphore_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thread_scheduler_join_semaphore_top_tb: scheduler regression
// Drives directed and random scheduling events through several semaphore
// limit settings with random idling on both channels; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module thread_scheduler_join_semaphore_top_tb;
   import tsjs_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 330;

   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [7:0] csr_data;
   logic       calm;
   int         fail_count;
   int         pending_count;
   int         checked_count;
   int         sent_count;
   int         cycle_count;
   int         stall_left;

   tsjs_if #(.payload_type(req_type)) req_ch ();
   tsjs_if #(.payload_type(rsp_type)) rsp_ch ();

   thread_scheduler_join_semaphore_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   thread_scheduler_join_semaphore_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_event(cmd_type cmd, logic [4:0] target, logic [1:0] sem);
      req_ch.valid <= 1'b1;
      req_ch.payload <= '{command: cmd, target_thread: target, sem_index: sem};
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic set_limits(logic [7:0] l0, logic [7:0] l1, logic [7:0] l2, logic [7:0] l3);
      logic [7:0] vals[4];
      vals = '{l0, l1, l2, l3};
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || rsp_ch.valid) @(posedge clock);
      repeat (80) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= 2'(i);
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   function automatic cmd_type pick_command();
      int w;
      w = $urandom_range(0, 99);
      if (w < 6) return CMD_CREATE;
      if (w < 26) return CMD_YIELD;
      if (w < 44) return CMD_TICK;
      if (w < 52) return CMD_JOIN;
      if (w < 54) return CMD_EXIT;
      if (w < 75) return CMD_WAIT;
      if (w < 97) return CMD_SIGNAL;
      return CMD_NONE;
   endfunction

   initial begin
      int wait_cycles;
      reset = 1'b1;
      calm = 1'b0;
      sent_count = 0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // before launch every command but create and none is refused
      send_event(CMD_SIGNAL, 5'd31, 2'd3);
      send_event(CMD_JOIN, 5'd0, 2'd0);
      send_event(CMD_NONE, 5'd31, 2'd3);
      send_event(CMD_CREATE, 5'd0, 2'd0);
      send_event(CMD_CREATE, 5'd0, 2'd0);
      send_event(CMD_TICK, 5'd0, 2'd0);
      send_event(CMD_YIELD, 5'd0, 2'd0);
      send_event(CMD_WAIT, 5'd0, 2'd0);
      send_event(CMD_WAIT, 5'd0, 2'd0);
      send_event(CMD_SIGNAL, 5'd0, 2'd0);
      send_event(CMD_SIGNAL, 5'd0, 2'd3);
      send_event(CMD_SIGNAL, 5'd0, 2'd3);
      send_event(CMD_JOIN, 5'd2, 2'd0);
      send_event(CMD_EXIT, 5'd0, 2'd0);
      send_event(CMD_YIELD, 5'd0, 2'd0);
      send_event(CMD_YIELD, 5'd0, 2'd0);
      send_event(CMD_TICK, 5'd0, 2'd0);
      send_event(CMD_JOIN, 5'd2, 2'd0);
      send_event(CMD_NONE, 5'd0, 2'd0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_limits(8'd0, 8'd255, 8'd0, 8'd255);
            1: set_limits(8'd255, 8'd0, 8'd255, 8'd0);
            2: set_limits(8'($urandom), 8'($urandom_range(0, 3)), 8'($urandom),
                          8'($urandom_range(0, 3)));
            default: set_limits(8'd1, 8'd1, 8'd1, 8'd1);
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 3 && k > PHASE_ITEMS - 120) calm = 1'b1;
            send_event(pick_command(), 5'($urandom_range(0, 31)),
                       2'($urandom_range(0, 3)));
         end
      end

      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);

      $display("sent %0d scheduling events over four semaphore limit settings", sent_count);
      $display("compared %0d result items", checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/tsjs_pkg.sv
rtl/tsjs_if.sv
rtl/tsjs_queues.sv
rtl/thread_scheduler_join_semaphore_top.sv
tb/thread_scheduler_join_semaphore_checker.sv
tb/thread_scheduler_join_semaphore_top_tb.sv
